// ===== rtl/quad_pid_motor_mixer_defines.svh =====
// assertion macros for the quad pid motor mixer
// no dependencies
`ifndef QUAD_PID_MOTOR_MIXER_DEFINES_SVH
`define QUAD_PID_MOTOR_MIXER_DEFINES_SVH
`ifndef ASSERT_OFF
`define QPM_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("qpm check");
`define QPM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("qpm check");
`else
`define QPM_ASSERT(label, cond)
`define QPM_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// ===== rtl/qpm_pkg.sv =====
// shared types and constants for the quad pid motor mixer
// no dependencies
package qpm_pkg;
  localparam int GainW = 24;
  localparam logic [23:0] GainResetPR = 24'h050A04;
  localparam logic signed [23:0] IntegMax = 24'sh7FFFFF;
  localparam logic signed [23:0] IntegMin = -24'sh800000;
  localparam logic [6:0] MotorMin = 7'd5;
  localparam logic [6:0] MotorMax = 7'd100;
  localparam logic [1:0] CfgPitch = 2'd0;
  localparam logic [1:0] CfgRoll = 2'd1;
  localparam logic [1:0] CfgYaw = 2'd2;
  typedef struct packed {
    logic start;
    logic [15:0] divisor;
    logic signed [39:0] dividend;
  } div_req_t;
  typedef struct packed {
    logic busy;
    logic done;
    logic signed [39:0] quot;
  } div_rsp_t;
endpackage

// ===== rtl/qpm_div.sv =====
// iterative signed divider, one quotient bit per cycle, truncating toward zero
// depends on qpm_pkg
module qpm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  qpm_pkg::div_req_t  req,
  output qpm_pkg::div_rsp_t  rsp
);
  logic [39:0] mag_r, mag_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r;
  logic        neg_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, done_r;
  logic [16:0] trial;
  logic [39:0] dmag;

  assign dmag = req.dividend[39] ? 40'(-req.dividend) : 40'(req.dividend);
  assign trial = {rem_r[15:0], mag_r[39]};

  always_comb begin
    rem_nxt = trial;
    mag_nxt = {mag_r[38:0], 1'b0};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = trial - {1'b0, dvs_r};
      mag_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd40;
        mag_r <= dmag;
        rem_r <= '0;
        dvs_r <= req.divisor;
        neg_r <= req.dividend[39];
      end else if (busy_r) begin
        mag_r <= mag_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_nxt;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? -$signed(mag_r) : $signed(mag_r);
endmodule

// ===== rtl/quad_pid_motor_mixer.sv =====
// top level of the quad pid motor mixer: sequencer, shared multiplier, state
// depends on qpm_pkg, qpm_div and quad_pid_motor_mixer_defines.svh
//
// usage
//   input channel: in_valid / in_stall, one transfer carries angles, targets,
//   throttle and elapsed time; in_stall is high while an item is in work
//   result channel: out_valid / out_stall, four motor drives per transfer
//   config port: cfg_we, cfg_index, cfg_data write the three gain registers
// sequence
//   each axis runs six steps, four of them on one shared 25x17 signed
//   multiplier, then the shared divider for the derivative term (start, 40
//   quotient bits, done); the three axes run in turn and a mix step follows;
//   one item is in work at a time
//   low throttle items show their result the cycle after the transfer
// reset
//   synchronous active-low; gains return to their defaults, integrators and
//   previous errors clear, no result is pending
// stall
//   a finished result waits in the output register while out_stall is high;
//   the next item is taken only after that result has moved
`include "quad_pid_motor_mixer_defines.svh"
module quad_pid_motor_mixer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] in_angle_x,
  input  logic signed [7:0] in_angle_y,
  input  logic signed [7:0] in_angle_z,
  input  logic [6:0]        in_pitch_target,
  input  logic [6:0]        in_roll_target,
  input  logic [6:0]        in_yaw_target,
  input  logic [6:0]        in_throttle_level,
  input  logic [15:0]       in_elapsed_time,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [6:0]        out_motor_front_a,
  output logic [6:0]        out_motor_front_b,
  output logic [6:0]        out_motor_rear_a,
  output logic [6:0]        out_motor_rear_b,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data
);
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StScale = 4'd1;
  localparam logic [3:0] StPMul  = 4'd2;
  localparam logic [3:0] StIMul  = 4'd3;
  localparam logic [3:0] StIAcc  = 4'd4;
  localparam logic [3:0] StDMul  = 4'd5;
  localparam logic [3:0] StDDiv  = 4'd6;
  localparam logic [3:0] StMix   = 4'd7;
  localparam logic [3:0] StIKi   = 4'd8;

  logic [3:0] st_r;
  logic [1:0] axis_r;
  logic [23:0] gain_r [3];
  logic signed [23:0] integ_r [3];
  logic signed [9:0] perr_r [3];

  // latched item
  logic signed [7:0] ang_r [3];
  logic [6:0] tgt_r [3];
  logic [6:0] thr_r;
  logic [15:0] dt_r;

  // error spans -269..141 for targets up to 127
  logic signed [9:0] err_r;
  logic signed [17:0] pterm_r;
  logic signed [24:0] iacc_r;
  logic signed [39:0] prod_r;
  logic signed [9:0] term_r [3];
  logic [6:0] mot_r [4];
  logic out_valid_r;
  logic div_wait_r;

  // shared multiplier: signed 25 x signed 17
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] mul_y;
  assign mul_y = mul_a * mul_b;

  logic [23:0] g;
  logic signed [9:0] ediff;
  logic signed [15:0] sc100;
  logic signed [8:0] scaled;
  assign g = gain_r[axis_r];
  assign ediff = err_r - perr_r[axis_r];
  assign sc100 = 16'(ang_r[axis_r]) * 16'sd100;
  // truncating division by 90 through multiply by reciprocal of magnitude
  logic [15:0] smag;
  logic [31:0] qrec;
  assign smag = sc100[15] ? 16'(-sc100) : 16'(sc100);
  assign qrec = (32'(smag) * 32'd46604) >> 22;
  assign scaled = sc100[15] ? -9'(qrec) : 9'(qrec);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_r)
      StPMul: begin mul_a = 25'($signed({1'b0, g[7:0]})); mul_b = 17'(err_r); end
      // ki * error first, then times the time step
      StIKi: begin mul_a = 25'($signed({1'b0, g[15:8]})); mul_b = 17'(err_r); end
      StIMul: begin mul_a = 25'(prod_r); mul_b = $signed({1'b0, dt_r}); end
      StDMul: begin mul_a = 25'($signed({1'b0, g[23:16]})); mul_b = 17'(ediff); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  qpm_pkg::div_req_t dreq;
  qpm_pkg::div_rsp_t drsp;
  assign dreq.start = (st_r == StDDiv) && !div_wait_r;
  assign dreq.divisor = (dt_r == 16'd0) ? 16'd1 : dt_r;
  assign dreq.dividend = prod_r <<< 16;

  qpm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic signed [25:0] isum;
  logic signed [25:0] ifloor;
  assign ifloor = 26'(prod_r >>> 16);
  assign isum = 26'(integ_r[axis_r]) + ifloor;

  logic signed [41:0] total;
  assign total = 42'(pterm_r) + 42'(iacc_r) + 42'(drsp.quot);

  function automatic logic [6:0] mclamp(input logic signed [11:0] v);
    if (v < 12'sd5) return qpm_pkg::MotorMin;
    if (v > 12'sd100) return qpm_pkg::MotorMax;
    return v[6:0];
  endfunction

  logic signed [11:0] tt, pp, rr, yy;
  assign tt = 12'($signed({1'b0, thr_r}));
  assign pp = 12'(term_r[0]);
  assign rr = 12'(term_r[1]);
  assign yy = 12'(term_r[2]);

  logic in_acc, out_acc;
  assign in_stall = (st_r != StIdle) || out_valid_r;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
      axis_r <= '0;
      out_valid_r <= 1'b0;
      div_wait_r <= 1'b0;
      gain_r[0] <= qpm_pkg::GainResetPR;
      gain_r[1] <= qpm_pkg::GainResetPR;
      gain_r[2] <= '0;
      for (int i = 0; i < 3; i++) begin
        integ_r[i] <= '0;
        perr_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == qpm_pkg::CfgPitch) gain_r[0] <= cfg_data;
        if (cfg_index == qpm_pkg::CfgRoll)  gain_r[1] <= cfg_data;
        if (cfg_index == qpm_pkg::CfgYaw)   gain_r[2] <= cfg_data;
      end
      if (out_acc) out_valid_r <= 1'b0;
      unique case (st_r)
        StIdle: begin
          if (in_acc) begin
            ang_r[0] <= in_angle_x; ang_r[1] <= in_angle_y; ang_r[2] <= in_angle_z;
            tgt_r[0] <= in_pitch_target; tgt_r[1] <= in_roll_target;
            tgt_r[2] <= in_yaw_target;
            thr_r <= in_throttle_level;
            // a zero time step counts as one
            dt_r <= (in_elapsed_time == 16'd0) ? 16'd1 : in_elapsed_time;
            axis_r <= '0;
            if (in_throttle_level <= qpm_pkg::MotorMin) begin
              for (int i = 0; i < 4; i++) mot_r[i] <= qpm_pkg::MotorMin;
              out_valid_r <= 1'b1;
            end else begin
              st_r <= StScale;
            end
          end
        end
        StScale: begin
          err_r <= 10'(scaled) - 10'($signed({1'b0, tgt_r[axis_r]}));
          st_r <= StPMul;
        end
        StPMul: begin pterm_r <= 18'(mul_y); st_r <= StIKi; end
        StIKi: begin prod_r <= 40'(mul_y); st_r <= StIMul; end
        StIMul: begin prod_r <= 40'(mul_y); st_r <= StIAcc; end
        StIAcc: begin
          if (isum > 26'(qpm_pkg::IntegMax)) iacc_r <= 25'(qpm_pkg::IntegMax);
          else if (isum < 26'(qpm_pkg::IntegMin)) iacc_r <= 25'(qpm_pkg::IntegMin);
          else iacc_r <= 25'(isum);
          st_r <= StDMul;
        end
        StDMul: begin
          integ_r[axis_r] <= 24'(iacc_r);
          prod_r <= 40'(mul_y);
          st_r <= StDDiv;
          div_wait_r <= 1'b0;
        end
        StDDiv: begin
          if (!div_wait_r) div_wait_r <= 1'b1;
          else if (drsp.done) begin
            div_wait_r <= 1'b0;
            perr_r[axis_r] <= err_r;
            if (total > 42'sd127) term_r[axis_r] <= 10'sd127;
            else if (total < -42'sd127) term_r[axis_r] <= -10'sd127;
            else term_r[axis_r] <= 10'(total);
            if (axis_r == 2'd2) st_r <= StMix;
            else begin
              axis_r <= axis_r + 2'd1;
              st_r <= StScale;
            end
          end
        end
        StMix: begin
          mot_r[0] <= mclamp(tt + pp - rr + yy);
          mot_r[1] <= mclamp(tt + pp + rr - yy);
          mot_r[2] <= mclamp(tt - pp + rr + yy);
          mot_r[3] <= mclamp(tt - pp - rr - yy);
          out_valid_r <= 1'b1;
          st_r <= StIdle;
        end
        default: st_r <= StIdle;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_motor_front_a = mot_r[0];
  assign out_motor_front_b = mot_r[1];
  assign out_motor_rear_a = mot_r[2];
  assign out_motor_rear_b = mot_r[3];

  `QPM_ASSERT_IMPL(a_busy_stall, st_r != StIdle, in_stall)
  `QPM_ASSERT_IMPL(a_out_hold, out_valid_r && out_stall, ##1 out_valid_r)
  `QPM_ASSERT_IMPL(a_div_only_ddiv, drsp.busy, st_r == StDDiv)
  `QPM_ASSERT(a_axis_range, axis_r != 2'd3)
endmodule
